FILE: src/sdb64_pkg.sv
//------------------------------------------------------------------------------
// sdb64_pkg: shared types and constants
// SHA-1 constants, base64 alphabet and sequencer states for the digest unit.
//------------------------------------------------------------------------------
package sdb64_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_EMIT
	} state_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] CHAR_EQ = 7'h3d;
	localparam logic [4:0] NUM_CHARS = 5'd28;

	// Map a 6-bit value to its base64 character
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] r;
		begin
			if (v < 6'd26) r = 7'h41 + {1'b0, v};
			else if (v < 6'd52) r = 7'h61 + {1'b0, v} - 7'd26;
			else if (v < 6'd62) r = 7'h30 + {1'b0, v} - 7'd52;
			else if (v == 6'd62) r = 7'h2b;
			else r = 7'h2f;
			return r;
		end
	endfunction

endpackage

FILE: src/sdb64_stream_if.sv
//------------------------------------------------------------------------------
// sdb64_stream_if: valid/ready channel
// Two handshake channels: message bytes in, base64 characters out.
//------------------------------------------------------------------------------
interface sdb64_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       is_last;
	logic       no_byte;
	modport source (output valid, msg_byte, is_last, no_byte, input ready);
	modport sink   (input valid, msg_byte, is_last, no_byte, output ready);
endinterface

interface sdb64_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;
	modport source (output valid, out_char, last_char, input ready);
	modport sink   (input valid, out_char, last_char, output ready);
endinterface

FILE: src/sha1_digest_base64_unit.sv
//------------------------------------------------------------------------------
// sha1_digest_base64_unit: streaming SHA-1 with base64 digest output
// Hashes a byte stream and emits the digest as 28 base64 characters.
//------------------------------------------------------------------------------
// A byte is accepted whenever the unit is idle. The 64th byte of a block
// starts the shared round unit, which runs one SHA-1 round per cycle and
// then folds the result into the hash, with the input held off. The last
// item adds one or two padded blocks, each loaded in a pad state before its
// rounds, then 28 characters leave one per cycle as the output side accepts
// them.
module sha1_digest_base64_unit (
	input  logic               clk,
	input  logic               arst_n,
	sdb64_in_if.sink           in_ch,
	sdb64_out_if.source        out_ch
);

	sdb64_pkg::state_t state_q, state_d;

	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [60:0] cnt_q;
	logic [6:0]  rnd_q;
	logic        last_q;      // padding pending after current block
	logic        second_q;    // second pad block (length only) is needed
	logic [4:0]  chr_q;
	logic [167:0] dig_q;

	logic acc_in, acc_out;
	logic [5:0] pos;
	logic [31:0] wt, f, k, tmp, wnew;

	assign acc_in  = in_ch.valid && in_ch.ready;
	assign acc_out = out_ch.valid && out_ch.ready;
	assign pos     = cnt_q[5:0];

	assign in_ch.ready     = (state_q == sdb64_pkg::ST_IDLE);
	assign out_ch.valid    = (state_q == sdb64_pkg::ST_EMIT);
	assign out_ch.last_char = (chr_q == sdb64_pkg::NUM_CHARS - 5'd1);
	assign out_ch.out_char = out_ch.last_char ? sdb64_pkg::CHAR_EQ
		: sdb64_pkg::b64_char(dig_q[167:162]);

	// Shared round unit: message schedule and one compression round
	always_comb begin
		wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wt   = (rnd_q < 7'd16) ? w_q[0] : {wnew[30:0], wnew[31]};
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sdb64_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sdb64_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sdb64_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sdb64_pkg::K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdb64_pkg::ST_IDLE: begin
				if (acc_in) begin
					if (!in_ch.no_byte && pos == 6'd63) state_d = sdb64_pkg::ST_ROUND;
					else if (in_ch.is_last) state_d = sdb64_pkg::ST_PAD;
				end
			end
			sdb64_pkg::ST_ROUND: if (rnd_q == 7'd79) state_d = sdb64_pkg::ST_FINAL;
			sdb64_pkg::ST_FINAL: begin
				if (second_q || last_q) state_d = sdb64_pkg::ST_PAD;
				else if (chr_q == 5'd1) state_d = sdb64_pkg::ST_EMIT;
				else state_d = sdb64_pkg::ST_IDLE;
			end
			sdb64_pkg::ST_PAD: state_d = sdb64_pkg::ST_ROUND;
			sdb64_pkg::ST_EMIT: begin
				if (acc_out && out_ch.last_char) state_d = sdb64_pkg::ST_IDLE;
			end
			default: state_d = sdb64_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sdb64_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rnd_q    <= '0;
			last_q   <= 1'b0;
			second_q <= 1'b0;
			chr_q    <= '0;
			h_q[0] <= sdb64_pkg::IV0; h_q[1] <= sdb64_pkg::IV1;
			h_q[2] <= sdb64_pkg::IV2; h_q[3] <= sdb64_pkg::IV3;
			h_q[4] <= sdb64_pkg::IV4;
		end else begin
			case (state_q)
				sdb64_pkg::ST_IDLE: begin
					rnd_q <= '0;
					chr_q <= '0;
					if (acc_in) begin
						if (!in_ch.no_byte) cnt_q <= cnt_q + 61'd1;
						last_q <= in_ch.is_last;
					end
				end
				sdb64_pkg::ST_ROUND: rnd_q <= rnd_q + 7'd1;
				sdb64_pkg::ST_FINAL: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					rnd_q <= '0;
					// chr_q==1 marks the closing block of a message
					if (!last_q && !second_q && chr_q == 5'd1) chr_q <= '0;
				end
				sdb64_pkg::ST_PAD: begin
					rnd_q <= '0;
					if (second_q) begin
						second_q <= 1'b0;
						chr_q    <= 5'd1;
					end else if (pos >= 6'd56) begin
						second_q <= 1'b1;
					end else begin
						chr_q <= 5'd1;
					end
					last_q <= 1'b0;
				end
				sdb64_pkg::ST_EMIT: begin
					if (acc_out) begin
						chr_q <= chr_q + 5'd1;
						if (out_ch.last_char) begin
							cnt_q <= '0;
							h_q[0] <= sdb64_pkg::IV0; h_q[1] <= sdb64_pkg::IV1;
							h_q[2] <= sdb64_pkg::IV2; h_q[3] <= sdb64_pkg::IV3;
							h_q[4] <= sdb64_pkg::IV4;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload: message window, working variables, digest shifter
	always_ff @(posedge clk) begin
		case (state_q)
			sdb64_pkg::ST_IDLE: begin
				if (acc_in && !in_ch.no_byte) begin
					case (pos[1:0])
						2'd0: w_q[pos[5:2]] <= {in_ch.msg_byte, 24'd0};
						2'd1: w_q[pos[5:2]][23:16] <= in_ch.msg_byte;
						2'd2: w_q[pos[5:2]][15:8] <= in_ch.msg_byte;
						default: w_q[pos[5:2]][7:0] <= in_ch.msg_byte;
					endcase
				end
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
				d_q <= h_q[3]; e_q <= h_q[4];
			end
			sdb64_pkg::ST_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wt;
				e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q; a_q <= tmp;
			end
			sdb64_pkg::ST_FINAL: begin
				dig_q <= {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q,
					h_q[3] + d_q, h_q[4] + e_q, 8'd0};
			end
			sdb64_pkg::ST_PAD: begin
				// Load padding; the round window rotates fully, so index is absolute
				if (second_q) begin
					for (int i = 0; i < 14; i++) w_q[i] <= '0;
				end else begin
					for (int i = 0; i < 16; i++) begin
						if (i == int'(pos[5:2])) begin
							case (pos[1:0])
								2'd0: w_q[i] <= {sdb64_pkg::PAD_BYTE, 24'd0};
								2'd1: w_q[i][23:0] <= {sdb64_pkg::PAD_BYTE, 16'd0};
								2'd2: w_q[i][15:0] <= {sdb64_pkg::PAD_BYTE, 8'd0};
								default: w_q[i][7:0] <= sdb64_pkg::PAD_BYTE;
							endcase
						end else if (i > int'(pos[5:2]) && (i < 14 || pos >= 6'd56)) begin
							// Length words are loaded below when they fit here
							w_q[i] <= '0;
						end
					end
				end
				if (second_q || pos < 6'd56) begin
					w_q[14] <= cnt_q[60:29];
					w_q[15] <= {cnt_q[28:0], 3'd0};
				end
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
				d_q <= h_q[3]; e_q <= h_q[4];
			end
			sdb64_pkg::ST_EMIT: if (acc_out) dig_q <= {dig_q[161:0], 6'd0};
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sdb64_pkg::ST_IDLE) |-> !in_ch.ready)
		else $error("input ready while busy");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdb64_pkg::ST_ROUND) |-> (rnd_q < 7'd80))
		else $error("round counter overflow");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_out && out_ch.last_char) |=> (state_q == sdb64_pkg::ST_IDLE && cnt_q == '0))
		else $error("message not restarted after digest");
	a_chr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdb64_pkg::ST_EMIT) |-> (chr_q < sdb64_pkg::NUM_CHARS))
		else $error("character index overflow");
`endif

endmodule

FILE: bench/sha1_b64_checker.sv
//------------------------------------------------------------------------------
// sha1_b64_checker: digest predictor and character comparator
// Watches both channels, computes SHA-1 over each accepted message and
// compares the emitted base64 characters one by one against the prediction.
//------------------------------------------------------------------------------
module sha1_b64_checker (
	input  logic        clk,
	input  logic        arst_n,
	sdb64_in_if.sink    msg_mon,
	sdb64_out_if.sink   chr_mon,
	output int          fail_count,
	output int          pending_chars
);

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} digest_char_t;

	logic [31:0]  hval [5];
	logic [31:0]  blk [16];
	logic [60:0]  nbytes;
	digest_char_t char_q [$];

	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	assign pending_chars = char_q.size();

	function automatic logic [31:0] rol(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// Run the 80 rounds over the current block and fold into the hash
	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, t;
		a = hval[0]; b = hval[1]; c = hval[2]; d = hval[3]; e = hval[4];
		w = blk;
		for (int r = 0; r < 80; r++) begin
			if (r < 16) wt = w[r];
			else begin
				wt = rol(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
				w[r & 15] = wt;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d); k = sdb64_pkg::K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = sdb64_pkg::K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = sdb64_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sdb64_pkg::K3;
			end
			t = rol(a, 5) + f + e + k + wt;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		hval[0] += a; hval[1] += b; hval[2] += c; hval[3] += d; hval[4] += e;
	endtask

	task automatic put_byte(input int pos, input logic [7:0] v);
		int sh;
		sh = (3 - (pos & 3)) * 8;
		if ((pos & 3) == 0) blk[pos >> 2] = 32'(v) << sh;
		else blk[pos >> 2] |= 32'(v) << sh;
	endtask

	task automatic restart();
		hval[0] = sdb64_pkg::IV0; hval[1] = sdb64_pkg::IV1; hval[2] = sdb64_pkg::IV2;
		hval[3] = sdb64_pkg::IV3; hval[4] = sdb64_pkg::IV4;
		nbytes = '0;
	endtask

	// Pad, finish the hash and queue the 28 expected characters
	task automatic finish_digest();
		int pos;
		logic [63:0] bits;
		logic [7:0] dig [21];
		logic [23:0] grp;
		digest_char_t dc;
		int n;
		pos = int'(nbytes[5:0]);
		bits = {nbytes, 3'b000};
		put_byte(pos, sdb64_pkg::PAD_BYTE);
		for (int i = (pos >> 2) + 1; i < 16; i++) blk[i] = '0;
		if (pos >= 56) begin
			compress();
			for (int i = 0; i < 14; i++) blk[i] = '0;
		end
		blk[14] = bits[63:32];
		blk[15] = bits[31:0];
		compress();
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 4; j++) dig[4 * i + j] = hval[i][31 - 8 * j -: 8];
		dig[20] = '0;
		n = 0;
		for (int i = 0; i < 21; i += 3) begin
			grp = {dig[i], dig[i + 1], dig[i + 2]};
			for (int j = 0; j < 4; j++) begin
				if (n == 27) dc.ch = sdb64_pkg::CHAR_EQ;
				else dc.ch = 7'(ALPHABET[grp[23 - 6 * j -: 6]]);
				dc.last = (n == 27);
				char_q.push_back(dc);
				n++;
			end
		end
		restart();
	endtask

	// Predict on every accepted input transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart();
			for (int i = 0; i < 16; i++) blk[i] = '0;
		end else if (msg_mon.valid && msg_mon.ready) begin
			if (!msg_mon.no_byte) begin
				put_byte(int'(nbytes[5:0]), msg_mon.msg_byte);
				nbytes = nbytes + 1'b1;
				if (nbytes[5:0] == 6'd0) compress();
			end
			if (msg_mon.is_last) finish_digest();
		end
	end

	// Compare every accepted output transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		digest_char_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else if (chr_mon.valid && chr_mon.ready) begin
			if (char_q.size() == 0) begin
				$display("%0t: unexpected char exp=none act=%h/%b", $realtime,
					chr_mon.out_char, chr_mon.last_char);
				fail_count <= fail_count + 1;
			end else begin
				want = char_q.pop_front();
				if (want.ch !== chr_mon.out_char || want.last !== chr_mon.last_char) begin
					$display("%0t: char mismatch exp=%h/%b act=%h/%b", $realtime,
						want.ch, want.last, chr_mon.out_char, chr_mon.last_char);
					fail_count <= fail_count + 1;
				end
			end
		end
	end
endmodule

FILE: bench/sha1_digest_base64_unit_tb.sv
//------------------------------------------------------------------------------
// sha1_digest_base64_unit_tb: stimulus and verdict
// Feeds directed and random messages with random gaps on both sides and
// reports the result from the checker's failure count.
//------------------------------------------------------------------------------
module sha1_digest_base64_unit_tb;
	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_chars;
	int   cycles;
	int   sent;

	sdb64_in_if  msg_ch ();
	sdb64_out_if chr_ch ();

	sha1_digest_base64_unit DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (msg_ch.sink),
		.out_ch(chr_ch.source)
	);

	sha1_b64_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_mon      (msg_ch.sink),
		.chr_mon      (chr_ch.sink),
		.fail_count   (fail_count),
		.pending_chars(pending_chars)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Send one transaction after a gap, then wait for acceptance
	task automatic send(input logic [7:0] b, input bit last, input bit nob, input int gap);
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid    <= 1'b1;
		msg_ch.msg_byte <= b;
		msg_ch.is_last  <= last;
		msg_ch.no_byte  <= nob;
		do @(posedge clk); while (!msg_ch.ready);
		sent++;
	endtask

	task automatic send_msg(input int len, input bit fixed, input logic [7:0] fill);
		for (int i = 0; i < len; i++)
			send(fixed ? fill : 8'($urandom), i == len - 1, 1'b0,
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
	endtask

	// Random output stalls, with stretches of no stalling
	always @(posedge clk or negedge arst_n) begin
		int hold;
		if (!arst_n) begin
			chr_ch.ready <= 1'b0;
		end else begin
			hold = (cycles % 2000 < 400) ? 0 : $urandom_range(0, 12);
			chr_ch.ready <= (hold == 0) || ($urandom_range(0, hold) == 0);
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int len;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.msg_byte = '0;
		msg_ch.is_last = 1'b0;
		msg_ch.no_byte = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: empty message, byte extremes, empty non-last items
		send(8'h00, 1'b1, 1'b1, 0);
		send(8'hff, 1'b1, 1'b0, 0);
		send(8'h00, 1'b1, 1'b0, 2);
		send(8'h5a, 1'b0, 1'b1, 0);
		send(8'ha5, 1'b0, 1'b0, 0);
		send(8'h3c, 1'b0, 1'b1, 1);
		send(8'hc3, 1'b1, 1'b1, 0);
		msg_ch.valid <= 1'b0;
		// Hold until the output side drains completely
		@(posedge clk);
		wait (pending_chars == 0);
		repeat (40) @(posedge clk);
		// Random messages, lengths around the block and padding boundaries
		while (sent < 380) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(1, 8);
				1: len = $urandom_range(54, 58);
				2: len = $urandom_range(62, 66);
				3: len = $urandom_range(118, 122);
				default: len = $urandom_range(1, 40);
			endcase
			if (len > 380 - sent) len = 380 - sent;
			if ($urandom_range(0, 6) == 0)
				send(8'($urandom), 1'b0, 1'b1, $urandom_range(0, 12));
			send_msg(len, $urandom_range(0, 7) == 0, $urandom_range(0, 1) ? 8'hff : 8'h00);
		end
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_chars == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
